FILE: rtl/bvc_pkg.sv
// Shared types and constants of the bijective base-128 varint codec.
package bvc_pkg;

    localparam int SYM_W = 64;
    localparam int BYTE_W = 8;
    localparam int POS_W = 4;

    typedef logic [SYM_W-1:0]  t_symbol;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;

    // Decode positions saturate here; weight 128^i is zero mod 2^64 from here on.
    localparam t_pos MAX_POS = 4'd10;
    // Index of the tenth encoded byte, the most a 64-bit symbol can need.
    localparam t_pos ENC_LAST = 4'd9;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sym;  // take a new symbol for encoding
        logic enc_step;  // emit one encoded byte
        logic dec_step;  // fold one byte into the accumulator
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enc_done;  // the byte about to be emitted is the final one
        logic out_free;  // output register can take a request this cycle
    } t_stat;

endpackage

FILE: rtl/bvc_if.sv
// Valid/ready channel interfaces of the varint codec.
interface bvc_in_if import bvc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_symbol symbol_in;
    t_byte   byte_in;

    modport source (output valid, output symbol_in, output byte_in, input ready);
    modport sink (input valid, input symbol_in, input byte_in, output ready);
endinterface

interface bvc_out_if import bvc_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    kind;
    t_byte   byte_out;
    t_symbol symbol_out;
    logic    last;

    modport source (output valid, output kind, output byte_out, output symbol_out,
                    output last, input ready);
    modport sink (input valid, input kind, input byte_out, input symbol_out,
                  input last, output ready);
endinterface

interface bvc_cfg_if import bvc_pkg::*; ();
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

FILE: rtl/bijective_varint_codec.sv
// Top level of the bijective base-128 varint codec.
//
// Channels: i_in takes one request at a time (symbol_in for encoding,
// byte_in for decoding); o_out delivers result requests (kind, byte_out,
// symbol_out, last); i_cfg writes the one-bit direction register
// (0 encode, 1 decode) and is always ready.
// Encode: a symbol is loaded into the remainder register, then the
// controller emits one byte per cycle while the receiver keeps up, one to
// ten bytes, the final one marked last. No new symbol is taken until the
// final byte has been emitted; each byte is shown in the output register.
// Decode: one byte per cycle while the receiver keeps up; a byte with bit
// 7 set only updates the accumulator and the digit position, a byte with
// bit 7 clear presents the symbol in the output register on the next
// cycle, last set.
// Reset (synchronous, active low) clears the direction to encode, the
// accumulator, the digit position and the output valid.
// When the receiver stalls, hold the output register; no new request is
// taken until it is free, and the encoder pauses between bytes.
module bijective_varint_codec import bvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bvc_in_if.sink     i_in,
    bvc_out_if.source  o_out,
    bvc_cfg_if.sink    i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: decides when to take a request and when to emit a byte.
    bvc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (i_in.ready),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_direction (i_cfg.direction),
        .o_cfg_ready     (i_cfg.ready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // Arithmetic and the output register.
    bvc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_symbol_in  (i_in.symbol_in),
        .i_byte_in    (i_in.byte_in),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_kind       (o_out.kind),
        .o_byte_out   (o_out.byte_out),
        .o_symbol_out (o_out.symbol_out),
        .o_last       (o_out.last)
    );

    // A request is only taken when the output register can receive its result.
    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!o_out.valid || o_out.ready))
        else $error("request taken while output register is blocked");

    // While a non-final encoded byte is shown, the encoder still owns the block.
    a_enc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_BYTE) && !o_out.last) |-> !i_in.ready)
        else $error("request taken in the middle of an encoded symbol");

    // A decoded symbol is always a single, final result with an empty byte field.
    a_symbol_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_SYMBOL)) |-> (o_out.last && (o_out.byte_out == '0)))
        else $error("malformed decoded symbol result");

    // Continuation bit and last flag of an encoded byte agree.
    a_byte_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_BYTE)) |-> (o_out.byte_out[7] != o_out.last))
        else $error("encoded byte continuation bit disagrees with last");

endmodule

FILE: rtl/bvc_ctrl.sv
// Controller state machine of the varint codec.
module bvc_ctrl import bvc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_cfg_valid,
    input  logic  i_cfg_direction,
    output logic  o_cfg_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ENC  = 1'b1;

    logic r_state, n_state;
    logic r_direction;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_direction <= DIR_ENCODE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_direction <= i_cfg_direction;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_direction == DIR_ENCODE) begin
                        o_cmd.load_sym = 1'b1;
                        n_state        = ST_ENC;
                    end else begin
                        o_cmd.dec_step = 1'b1;
                    end
                end
            end
            ST_ENC: begin
                if (i_stat.out_free) begin
                    o_cmd.enc_step = 1'b1;
                    if (i_stat.enc_done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/bvc_dp.sv
// Datapath of the varint codec: encoder remainder, decode accumulator, output register.
module bvc_dp import bvc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  t_symbol i_symbol_in,
    input  t_byte   i_byte_in,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_kind,
    output t_byte   o_byte_out,
    output t_symbol o_symbol_out,
    output logic    o_last
);

    t_symbol r_remaining;
    t_pos    r_enc_cnt;
    t_symbol r_acc;
    t_pos    r_pos;
    logic    r_valid;
    logic    r_kind;
    t_byte   r_byte;
    t_symbol r_symbol;
    logic    r_last;

    logic    rem_small;
    t_symbol n_remaining;
    logic [5:0] shamt;
    t_symbol term;
    t_symbol n_acc;

    // Bijective step: (v - low - 128) / 128 is (v >> 7) - 1 for v >= 128.
    assign rem_small   = (r_remaining[SYM_W-1:7] == '0);
    assign n_remaining = {7'd0, r_remaining[SYM_W-1:7]} - t_symbol'(1);

    // Weight 128^pos as a shift by 7*pos; positions at the cap add nothing.
    assign shamt = 6'({r_pos, 3'b000} - {3'b000, r_pos});
    assign term  = (r_pos < MAX_POS) ? (t_symbol'(i_byte_in) << shamt) : '0;
    assign n_acc = r_acc + term;

    assign o_stat.enc_done = rem_small || (r_enc_cnt == ENC_LAST);
    assign o_stat.out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_remaining <= '0;
            r_enc_cnt   <= '0;
        end else begin
            if (i_cmd.enc_step || (i_cmd.dec_step && !i_byte_in[7])) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.load_sym) begin
                r_remaining <= i_symbol_in;
                r_enc_cnt   <= '0;
            end
            if (i_cmd.enc_step) begin
                r_remaining <= n_remaining;
                r_enc_cnt   <= r_enc_cnt + t_pos'(1);
            end
            if (i_cmd.dec_step) begin
                if (i_byte_in[7]) begin
                    r_acc <= n_acc;
                    if (r_pos < MAX_POS) begin
                        r_pos <= r_pos + t_pos'(1);
                    end
                end else begin
                    r_acc   <= '0;
                    r_pos   <= '0;
                end
            end
        end
    end

    // Output payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.enc_step) begin
            r_kind   <= KIND_BYTE;
            r_byte   <= {!rem_small, r_remaining[6:0]};
            r_symbol <= '0;
            r_last   <= rem_small;
        end else if (i_cmd.dec_step && !i_byte_in[7]) begin
            r_kind   <= KIND_SYMBOL;
            r_byte   <= '0;
            r_symbol <= n_acc;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_byte_out   = r_byte;
    assign o_symbol_out = r_symbol;
    assign o_last       = r_last;

endmodule
